// ----- hdl/c16alc_pkg.sv -----
// Shared types, constants and CRC helpers for the CRC-16 address/length check.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package c16alc_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned ADDR_W  = 29;
   localparam int unsigned CRC_W   = 16;
   localparam int unsigned COUNT_W = 7;

   // Byte count limits
   localparam logic [COUNT_W-1:0] COUNT_MAX  = 7'd64;
   localparam logic [COUNT_W-1:0] SKIP_BYTES = 7'd2;

   // Message lengths that carry a length-dependent XOR
   localparam logic [COUNT_W-1:0] LEN_8  = 7'd8;
   localparam logic [COUNT_W-1:0] LEN_16 = 7'd16;
   localparam logic [COUNT_W-1:0] LEN_24 = 7'd24;
   localparam logic [COUNT_W-1:0] LEN_32 = 7'd32;

   localparam logic [CRC_W-1:0] XOR_LEN_8  = 16'h5f29;
   localparam logic [CRC_W-1:0] XOR_LEN_16 = 16'h041d;
   localparam logic [CRC_W-1:0] XOR_LEN_24 = 16'h819d;
   localparam logic [CRC_W-1:0] XOR_LEN_32 = 16'h9f5b;

   // One input transaction
   typedef struct packed {
      logic [BYTE_W-1:0] payload_byte;
      logic              message_start;
      logic              message_end;
      logic [ADDR_W-1:0] message_address;
   } item_type;

   // One result transaction
   typedef struct packed {
      logic [CRC_W-1:0]   crc_value;
      logic [COUNT_W-1:0] message_bytes;
   } result_type;

   // Byte-wise CRC-16 update, polynomial 0x1021, MSB first (closed XOR form)
   function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] x;
      x = crc[15:8] ^ data;
      x = x ^ (x >> 4);
      return {crc[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000}
             ^ {8'h00, x};
   endfunction

   // Final XOR picked by message length
   function automatic logic [CRC_W-1:0] length_xor(input logic [COUNT_W-1:0] count);
      logic [CRC_W-1:0] mask;
      case (count)
         LEN_8:   mask = XOR_LEN_8;
         LEN_16:  mask = XOR_LEN_16;
         LEN_24:  mask = XOR_LEN_24;
         LEN_32:  mask = XOR_LEN_32;
         default: mask = '0;
      endcase
      return mask;
   endfunction

endpackage

// ----- hdl/c16alc_in_stage.sv -----
// Input register for the CRC-16 check: holds one request transaction.
// Depends on c16alc_pkg.
`timescale 1ns / 1ps

module c16alc_in_stage
   import c16alc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  item_type req_item,
   output logic     item_valid,
   input  logic     item_ready,
   output item_type item
);

   logic     valid_ff, valid_in;
   item_type item_ff;
   logic     take;

   // Refill whenever the held transaction leaves or the register is empty
   assign take      = valid_ff && item_ready;
   assign req_ready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture payload on acceptance
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ----- hdl/c16alc_core.sv -----
// Running CRC and byte count; takes one byte per transaction, finishes on end mark.
// Depends on c16alc_pkg.
`timescale 1ns / 1ps

module c16alc_core
   import c16alc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       item_valid,
   output logic       item_ready,
   input  item_type   item,
   output logic       res_valid,
   input  logic       res_ready,
   output result_type res
);

   logic [CRC_W-1:0]   crc_ff, crc_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [CRC_W-1:0]   crc_base, crc_byte, crc_addr;
   logic [COUNT_W-1:0] count_base, count_new;
   logic               fire;

   // Non-final bytes never wait; the final byte needs room for its result
   assign item_ready = !item.message_end || res_ready;
   assign fire       = item_valid && item_ready;

   // Fold the byte unless it belongs to the checksum field
   always_comb begin
      crc_base   = item.message_start ? '0 : crc_ff;
      count_base = item.message_start ? '0 : count_ff;
      crc_byte   = (count_base >= SKIP_BYTES) ?
                   crc_fold(crc_base, item.payload_byte) : crc_base;
      count_new  = (count_base < COUNT_MAX) ? count_base + 7'd1 : count_base;
      crc_addr   = crc_fold(crc_fold(crc_byte, item.message_address[7:0]),
                            item.message_address[15:8]);
   end

   // Advance state; clear it after the last byte of a message
   always_comb begin
      crc_in   = crc_ff;
      count_in = count_ff;
      if (fire) begin
         if (item.message_end) begin
            crc_in   = '0;
            count_in = '0;
         end else begin
            crc_in   = crc_byte;
            count_in = count_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= '0;
         count_ff <= '0;
      end else begin
         crc_ff   <= crc_in;
         count_ff <= count_in;
      end
   end

   assign res_valid         = fire && item.message_end;
   assign res.crc_value     = crc_addr ^ length_xor(count_new);
   assign res.message_bytes = count_new;

endmodule

// ----- hdl/c16alc_out_stage.sv -----
// Result register for the CRC-16 check: holds one response transaction.
// Depends on c16alc_pkg.
`timescale 1ns / 1ps

module c16alc_out_stage
   import c16alc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       res_valid,
   output logic       res_ready,
   input  result_type res,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp
);

   logic       valid_ff, valid_in;
   result_type res_ff;

   // Accept a new result when empty or when the held one drains this cycle
   assign res_ready = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (res_valid && res_ready) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         res_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = res_ff;

endmodule

// ----- hdl/crc16_address_length_check.sv -----
// CRC-16 (poly 0x1021, init 0) over message payload plus address, with length XOR.
//
// Request channel (req_*): one payload byte per transaction with start/end marks
// and the message address (bits 15..0 used on the end byte). The first two
// bytes of a message are counted but not folded. Response channel (rsp_*): one
// transaction per message, on its end byte: check value and byte count (caps
// at 64). Bytes without an end mark give no response.
// Path: a request passes one input register, single-pass logic between, and
// one result register before it shows as a response.
// Throughput: one request per cycle while the result register takes end bytes;
// the per-byte CRC update is a short XOR network; messages flow with no gaps.
// Stall: while a response waits, non-final bytes keep flowing; an end byte
// waits in the input register until the result register frees up, and
// req_ready then drops.
// Reset (synchronous, active high): clears both valid flags, the running CRC
// and the byte count; bytes before any start mark begin a message from reset.
`timescale 1ns / 1ps

module crc16_address_length_check
   import c16alc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [BYTE_W-1:0]   req_payload_byte,
   input  logic                req_message_start,
   input  logic                req_message_end,
   input  logic [ADDR_W-1:0]   req_message_address,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [CRC_W-1:0]    rsp_crc_value,
   output logic [COUNT_W-1:0]  rsp_message_bytes
);

   item_type   req_item, item;
   result_type res, rsp;
   logic       item_valid, item_ready;
   logic       res_valid, res_ready;

   assign req_item.payload_byte    = req_payload_byte;
   assign req_item.message_start   = req_message_start;
   assign req_item.message_end     = req_message_end;
   assign req_item.message_address = req_message_address;

   // Input register
   c16alc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item)
   );

   // CRC and count update
   c16alc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res)
   );

   // Result register
   c16alc_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_crc_value     = rsp.crc_value;
   assign rsp_message_bytes = rsp.message_bytes;

endmodule

// ----- hdl/c16alc_checker.sv -----
// Port-level checks for crc16_address_length_check, attached by bind.
// Depends on c16alc_pkg.
`timescale 1ns / 1ps

module c16alc_checker
   import c16alc_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [CRC_W-1:0]   rsp_crc_value,
   input logic [COUNT_W-1:0] rsp_message_bytes
);

   // A response counts at least its end byte and never more than the cap
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_message_bytes != 7'd0) && (rsp_message_bytes <= COUNT_MAX))
      else $error("response byte count out of range");

   // Nothing is pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // With the result register free, an offered request is never stalled
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && !rsp_valid |-> req_ready)
      else $error("request stalled with empty result register");

   // A stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_crc_value)
                                  && $stable(rsp_message_bytes))
      else $error("stalled response changed");

endmodule

bind crc16_address_length_check c16alc_checker u_c16alc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_crc_value     (rsp_crc_value),
   .rsp_message_bytes (rsp_message_bytes)
);

// ----- sim/tb_crc16_address_length_check.sv -----
// Self-checking testbench for crc16_address_length_check: predicts the check
// value and byte count of each message and compares every response transaction.
// Depends on c16alc_pkg and the crc16_address_length_check RTL only.
`timescale 1ns / 1ps

import c16alc_pkg::*;

// Tracks the running CRC of the current message and holds expected responses
class crc_length_tracker;
   localparam logic [CRC_W-1:0] POLY = 16'h1021;

   logic [CRC_W-1:0]   crc_acc  = '0;
   logic [COUNT_W-1:0] byte_cnt = '0;
   result_type         expected_checks[$];
   int unsigned        failures = 0;

   // Shift one byte through the CRC register, MSB first
   function logic [CRC_W-1:0] fold_byte(logic [CRC_W-1:0] crc, logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] c;
      c = crc ^ {data, 8'h00};
      for (int k = 0; k < 8; k++)
         c = c[15] ? ((c << 1) ^ POLY) : (c << 1);
      return c;
   endfunction

   function void flag(string what);
      failures++;
      if (failures <= 10)
         $display("[%0t] mismatch: %s", $time, what);
   endfunction

   // Advance the prediction by one accepted request transaction
   function void note_byte(item_type it);
      logic [CRC_W-1:0] c;
      result_type       r;
      if (it.message_start) begin
         crc_acc  = '0;
         byte_cnt = '0;
      end
      // Skip the checksum field, saturate the count
      if (byte_cnt >= SKIP_BYTES)
         crc_acc = fold_byte(crc_acc, it.payload_byte);
      if (byte_cnt < COUNT_MAX)
         byte_cnt = byte_cnt + 1'b1;
      if (!it.message_end)
         return;
      // Fold in the address, low byte first, then apply the length mask
      c = fold_byte(crc_acc, it.message_address[7:0]);
      c = fold_byte(c, it.message_address[15:8]);
      case (byte_cnt)
         LEN_8:   c ^= XOR_LEN_8;
         LEN_16:  c ^= XOR_LEN_16;
         LEN_24:  c ^= XOR_LEN_24;
         LEN_32:  c ^= XOR_LEN_32;
         default: ;
      endcase
      r.crc_value     = c;
      r.message_bytes = byte_cnt;
      expected_checks.push_back(r);
      crc_acc  = '0;
      byte_cnt = '0;
   endfunction

   // Compare one response transaction with the oldest expectation
   function void check_result(result_type got);
      result_type want;
      if (expected_checks.size() == 0) begin
         flag($sformatf("unexpected response crc_value %h message_bytes %0d",
                        got.crc_value, got.message_bytes));
         return;
      end
      want = expected_checks.pop_front();
      if (got.crc_value !== want.crc_value)
         flag($sformatf("crc_value expected %h actual %h", want.crc_value, got.crc_value));
      if (got.message_bytes !== want.message_bytes)
         flag($sformatf("message_bytes expected %0d actual %0d",
                        want.message_bytes, got.message_bytes));
   endfunction
endclass

module tb_crc16_address_length_check;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [BYTE_W-1:0]   req_payload_byte;
   logic                req_message_start;
   logic                req_message_end;
   logic [ADDR_W-1:0]   req_message_address;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [CRC_W-1:0]    rsp_crc_value;
   logic [COUNT_W-1:0]  rsp_message_bytes;

   crc_length_tracker tracker;
   int unsigned       send_idle_pct  = 0;
   int unsigned       recv_stall_pct = 0;
   int unsigned       hold_request   = 0;

   crc16_address_length_check dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_payload_byte    (req_payload_byte),
      .req_message_start   (req_message_start),
      .req_message_end     (req_message_end),
      .req_message_address (req_message_address),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_crc_value       (rsp_crc_value),
      .rsp_message_bytes   (rsp_message_bytes)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watch both channels; note requests before checking responses
   always @(posedge clock) begin
      item_type   seen;
      result_type got;
      if (!reset && req_valid && req_ready) begin
         seen.payload_byte    = req_payload_byte;
         seen.message_start   = req_message_start;
         seen.message_end     = req_message_end;
         seen.message_address = req_message_address;
         tracker.note_byte(seen);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         got.crc_value     = rsp_crc_value;
         got.message_bytes = rsp_message_bytes;
         tracker.check_result(got);
      end
   end

   // Drive response ready: random stalls, plus long hold-offs on request
   initial begin
      int unsigned hold_left;
      hold_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   function automatic item_type make_item(logic [BYTE_W-1:0] b, logic s, logic e,
                                          logic [ADDR_W-1:0] a);
      item_type it;
      it.payload_byte    = b;
      it.message_start   = s;
      it.message_end     = e;
      it.message_address = a;
      return it;
   endfunction

   // Offer one request transaction and hold it until accepted
   task automatic send_item(item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_payload_byte    <= it.payload_byte;
      req_message_start   <= it.message_start;
      req_message_end     <= it.message_end;
      req_message_address <= it.message_address;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   // Send a message of random content; the address changes on every byte
   task automatic send_message(int len, bit with_start, bit with_end, ref int sent);
      for (int i = 0; i < len; i++) begin
         send_item(make_item(BYTE_W'($urandom), with_start && i == 0,
                             with_end && i == len - 1, ADDR_W'($urandom)));
         sent++;
      end
   endtask

   initial begin
      int sent;
      int phase_sent;
      int len;
      int pick;

      tracker = new();
      sent    = 0;
      reset               <= 1'b1;
      req_valid           <= 1'b0;
      req_payload_byte    <= '0;
      req_message_start   <= 1'b0;
      req_message_end     <= 1'b0;
      req_message_address <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Bytes before any start mark count as a message begun at reset
      send_item(make_item(8'hFF, 1'b0, 1'b0, '1));
      send_item(make_item(8'h00, 1'b0, 1'b0, '1));
      send_item(make_item(8'hA5, 1'b0, 1'b1, '1));
      // One-byte message: only the address is folded
      send_item(make_item(8'hFF, 1'b1, 1'b1, '0));
      // Two-byte message: checksum field only
      send_item(make_item(8'h00, 1'b1, 1'b0, 29'h0000FFFF));
      send_item(make_item(8'hFF, 1'b0, 1'b1, 29'h0000FFFF));
      // Eight bytes take the length mask
      for (int i = 0; i < 8; i++)
         send_item(make_item(BYTE_W'($urandom), i == 0, i == 7, 29'h1FFF0000));
      // Fresh message after an end without a start mark
      send_item(make_item(8'h80, 1'b0, 1'b0, 29'h1ABC1234));
      send_item(make_item(8'h01, 1'b0, 1'b0, 29'h1ABC1234));
      send_item(make_item(8'h7F, 1'b0, 1'b0, 29'h1ABC1234));
      send_item(make_item(8'hFE, 1'b0, 1'b1, 29'h1ABC1234));
      // A start mark in the middle restarts the message
      send_item(make_item(8'h55, 1'b1, 1'b0, 29'h00000000));
      send_item(make_item(8'hAA, 1'b0, 1'b0, 29'h00000000));
      send_item(make_item(8'h3C, 1'b1, 1'b0, 29'h15555555));
      send_item(make_item(8'hC3, 1'b0, 1'b0, 29'h0AAAAAAA));
      send_item(make_item(8'h99, 1'b0, 1'b1, 29'h0AAAAAAA));

      // Random traffic in four idling phases
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
            default: begin send_idle_pct = 13; recv_stall_pct = 13; end
         endcase
         // Hold the response side off so the block backs up into the request side
         if (phase == 0 || phase == 2)
            hold_request = 80;
         phase_sent = 0;
         while (phase_sent < 225) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
               // Noise: random marks on every byte
               len = $urandom_range(1, 6);
               for (int i = 0; i < len; i++) begin
                  send_item(make_item(BYTE_W'($urandom), $urandom_range(2) == 0,
                                      $urandom_range(2) == 0, ADDR_W'($urandom)));
                  phase_sent++;
               end
            end else if (pick < 16) begin
               // Broken message: never ends, the next start cuts it off
               send_message($urandom_range(1, 10), 1'b1, 1'b0, phase_sent);
            end else if (pick < 22) begin
               // Saturating count
               send_message($urandom_range(64, 72), 1'b1, 1'b1, phase_sent);
            end else if (pick < 40) begin
               // Masked lengths and their neighbors
               len = 8 * $urandom_range(1, 4);
               if ($urandom_range(3) == 0)
                  len = $urandom_range(1) ? len + 1 : len - 1;
               send_message(len, $urandom_range(9) != 0, 1'b1, phase_sent);
            end else begin
               send_message($urandom_range(1, 12), $urandom_range(9) != 0, 1'b1,
                            phase_sent);
            end
         end
         sent += phase_sent;
      end

      // Drain
      req_valid      <= 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      @(posedge clock);
      while (tracker.expected_checks.size() != 0)
         @(posedge clock);
      repeat (5) @(posedge clock);

      if (tracker.failures == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Watchdog
   initial begin
      #4_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
